>>> design/gbkp_pkg.sv
// Shared types, constants and codes of the grid bucket best-keypoint unit.
// Used by every module of the block; depends on nothing else.
package gbkp_pkg;

   localparam int CFG_W        = 12;
   localparam int DIV_W        = 12;
   localparam int IDX_W        = 2 * DIV_W + 1;
   localparam int POS_W        = 16;
   localparam int RESP_W       = 32;
   localparam int REQ_W        = 10;
   localparam int KIND_W       = 3;
   localparam int CSR_IDX_W    = 2;
   localparam int PAY_W        = RESP_W + 2 * POS_W;
   localparam int REQ_TDATA_W  = 80;
   localparam int RSP_TDATA_W  = 2 * POS_W;
   localparam int MAX_CELLS_DEF = 1024;

   localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
   localparam logic [CFG_W-1:0] CSIZE_RST  = 12'd32;
   localparam logic [DIV_W-1:0] COLS_RST   = 12'd20;
   localparam logic [DIV_W-1:0] ROWS_RST   = 12'd15;

   localparam logic signed [RESP_W-1:0] EMPTY_SCORE = -32'sd65536;

   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_CLR_OCC = 3'd0;
   localparam kind_type KIND_MARK    = 3'd1;
   localparam kind_type KIND_OFFER   = 3'd2;
   localparam kind_type KIND_READ    = 3'd3;
   localparam kind_type KIND_CLR_WIN = 3'd4;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_WIDTH  = 2'd0;
   localparam csr_idx_type REG_HEIGHT = 2'd1;
   localparam csr_idx_type REG_CSIZE  = 2'd2;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_GRID,
      ST_DIV,
      ST_MUL,
      ST_ADDR,
      ST_LOOK,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic occ_we;
      logic occ_wd;
      logic val_we;
      logic val_wd;
      logic pay_we;
      logic sweep_start;
      logic sweep_occ;
      logic sweep_val;
   } store_ctl_type;

   typedef struct packed {
      logic                     busy;
      logic                     occ;
      logic                     valid;
      logic signed [RESP_W-1:0] score;
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
   } store_rd_type;

endpackage

>>> design/grid_bucket_best_keypoint_unit.sv
// Top level of the grid bucket best-keypoint unit: sequencer, grid registers and result register.
// Depends on gbkp_pkg, gbkp_serial_div and gbkp_cell_store.
//
// The unit keeps the best keypoint of each square image cell and refuses cells that are marked
// by tracked points. A pair of bit-serial dividers finds column and row of a mark or an offer
// at one quotient bit per cycle. A point with a negative coordinate is dropped without being
// divided. A read passes through a look-up and an apply state and waits in the latter for the
// result register to drain. Clearing occupancy or winners sweeps the matching cell memory one
// entry per cycle. After reset a sweep of both memories runs, and no transfer is taken until it
// ends. After a register write the next item waits while the grid size is recomputed. One item
// is in work at a time; a finished result waits in its register while the next item is taken.
module grid_bucket_best_keypoint_unit #(
   parameter int MAX_CELLS = gbkp_pkg::MAX_CELLS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pos_x, pos_y, response, cell_req, zero padding
   input  logic [gbkp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // kind
   input  logic [gbkp_pkg::KIND_W-1:0]          req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // win_x, win_y
   output logic [gbkp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // has_point
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [gbkp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gbkp_pkg::CFG_W-1:0]           csr_wdata
);
   import gbkp_pkg::*;

   localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_CELLS);

   state_type state_ff;
   state_type state_in;

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [CFG_W-1:0] csize_ff;
   logic             dirty_ff;
   logic [DIV_W-1:0] cols_ff;
   logic [DIV_W-1:0] rows_ff;

   kind_type                 kind_ff;
   logic signed [POS_W-1:0]  x_ff;
   logic signed [POS_W-1:0]  y_ff;
   logic signed [RESP_W-1:0] resp_ff;
   logic                     in_grid_ff;
   logic [2*DIV_W-1:0]       prod_ff;
   logic [CELL_W-1:0]        addr_ff;
   logic                     ok_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_has_ff;
   logic signed [POS_W-1:0] rsp_x_ff;
   logic signed [POS_W-1:0] rsp_y_ff;

   kind_type                 in_kind;
   logic signed [POS_W-1:0]  in_x;
   logic signed [POS_W-1:0]  in_y;
   logic signed [RESP_W-1:0] in_resp;
   logic [REQ_W-1:0]         in_cell;
   logic [IDX_W-1:0]         in_cell_idx;

   logic             accept;
   logic             grid_start;
   logic             item_div;
   logic             div_start;
   logic [DIV_W-1:0] div_a_x;
   logic [DIV_W-1:0] div_a_y;
   logic             done_x;
   logic             done_y;
   logic             div_done;
   logic [DIV_W-1:0] quo_x;
   logic [DIV_W-1:0] quo_y;
   logic [IDX_W-1:0] idx;
   logic             rsp_free;
   logic             rsp_load;
   logic             take_win;
   logic signed [RESP_W-1:0] cur_score;

   store_ctl_type ctl;
   store_rd_type  rd;

   assign in_kind     = req_tuser;
   assign in_x        = req_tdata[POS_W-1:0];
   assign in_y        = req_tdata[2*POS_W-1:POS_W];
   assign in_resp     = req_tdata[2*POS_W+RESP_W-1:2*POS_W];
   assign in_cell     = req_tdata[2*POS_W+RESP_W+REQ_W-1:2*POS_W+RESP_W];
   assign in_cell_idx = IDX_W'(in_cell);

   assign accept   = req_tvalid && req_tready;
   assign div_done = done_x && done_y;
   assign idx      = IDX_W'(quo_y) + IDX_W'(prod_ff);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign cur_score = rd.valid ? rd.score : EMPTY_SCORE;

   gbkp_serial_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a_x),
      .divisor  (csize_ff),
      .done     (done_x),
      .quotient (quo_x)
   );

   gbkp_serial_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a_y),
      .divisor  (csize_ff),
      .done     (done_y),
      .quotient (quo_y)
   );

   gbkp_cell_store #(
      .MAX_CELLS (MAX_CELLS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .addr     (addr_ff),
      .wr_score (resp_ff),
      .wr_x     (x_ff),
      .wr_y     (y_ff),
      .rd       (rd)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (!rd.busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (grid_start) begin
               state_in = ST_GRID;
            end else if (accept) begin
               unique case (in_kind)
                  KIND_CLR_OCC, KIND_CLR_WIN: state_in = ST_SWEEP;
                  KIND_MARK, KIND_OFFER:      state_in = item_div ? ST_DIV : ST_IDLE;
                  KIND_READ:                  state_in = ST_LOOK;
                  default:                    state_in = ST_IDLE;
               endcase
            end
         end
         ST_GRID: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (kind_ff == KIND_READ || (ok_ff && kind_ff == KIND_OFFER)) begin
               state_in = ST_APPLY;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_APPLY: begin
            if (kind_ff == KIND_READ && !rsp_free) begin
               state_in = ST_APPLY;
            end else begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE) && !dirty_ff;
      grid_start = (state_ff == ST_IDLE) && dirty_ff;
      item_div   = accept && (in_kind == KIND_MARK || in_kind == KIND_OFFER)
                   && !in_x[POS_W-1] && !in_y[POS_W-1];
      div_start  = grid_start || item_div;
      div_a_x    = grid_start ? width_ff : {1'b0, in_x[POS_W-2:4]};
      div_a_y    = grid_start ? height_ff : {1'b0, in_y[POS_W-2:4]};

      ctl             = '0;
      ctl.sweep_start = accept && (in_kind == KIND_CLR_OCC || in_kind == KIND_CLR_WIN);
      ctl.sweep_occ   = in_kind == KIND_CLR_OCC;
      ctl.sweep_val   = in_kind == KIND_CLR_WIN;
      take_win        = 1'b0;
      rsp_load        = 1'b0;

      unique case (state_ff)
         ST_LOOK: begin
            ctl.rd_en  = ok_ff && (kind_ff == KIND_OFFER || kind_ff == KIND_READ);
            ctl.occ_we = ok_ff && kind_ff == KIND_MARK;
            ctl.occ_wd = 1'b1;
         end
         ST_APPLY: begin
            take_win   = kind_ff == KIND_OFFER && !rd.occ && resp_ff >= cur_score;
            rsp_load   = kind_ff == KIND_READ && rsp_free;
            ctl.val_we = take_win || (rsp_load && ok_ff);
            ctl.val_wd = take_win;
            ctl.pay_we = take_win;
         end
         default: begin
            ctl.rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         width_ff     <= WIDTH_RST;
         height_ff    <= HEIGHT_RST;
         csize_ff     <= CSIZE_RST;
         dirty_ff     <= 1'b0;
         cols_ff      <= COLS_RST;
         rows_ff      <= ROWS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (grid_start) begin
            dirty_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_WIDTH:  width_ff  <= csr_wdata;
               REG_HEIGHT: height_ff <= csr_wdata;
               REG_CSIZE:  csize_ff  <= csr_wdata;
               default:    width_ff  <= width_ff;
            endcase
            if (csr_index == REG_WIDTH || csr_index == REG_HEIGHT
                || csr_index == REG_CSIZE) begin
               dirty_ff <= 1'b1;
            end
         end
         if (state_ff == ST_GRID && div_done) begin
            cols_ff <= (csize_ff == '0) ? '0 : quo_x;
            rows_ff <= (csize_ff == '0) ? '0 : quo_y;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= in_kind;
         x_ff    <= in_x;
         y_ff    <= in_y;
         resp_ff <= in_resp;
         addr_ff <= in_cell_idx[CELL_W-1:0];
         ok_ff   <= in_cell_idx < MAX_IDX;
      end
      if (state_ff == ST_MUL) begin
         prod_ff    <= (2*DIV_W)'(quo_x) * (2*DIV_W)'(rows_ff);
         in_grid_ff <= (quo_x < cols_ff) && (quo_y < rows_ff);
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= idx[CELL_W-1:0];
         ok_ff   <= in_grid_ff && (idx < MAX_IDX);
      end
      if (rsp_load) begin
         rsp_has_ff <= ok_ff && rd.valid;
         rsp_x_ff   <= (ok_ff && rd.valid) ? rd.x : '0;
         rsp_y_ff   <= (ok_ff && rd.valid) ? rd.y : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_has_ff;

endmodule

>>> design/gbkp_serial_div.sv
// Restoring divider that produces one quotient bit per clock cycle.
// Depends on gbkp_pkg for the operand width.
module gbkp_serial_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gbkp_pkg::DIV_W-1:0] dividend,
   input  logic [gbkp_pkg::DIV_W-1:0] divisor,
   output logic                       done,
   output logic [gbkp_pkg::DIV_W-1:0] quotient
);
   import gbkp_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W:0]   shifted;
   logic [DIV_W+1:0] diff;
   logic             fits;
   logic [DIV_W-1:0] rem_in;
   logic [DIV_W-1:0] quo_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      fits    = ~diff[DIV_W+1];
      rem_in  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_in  = {quo_ff[DIV_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(DIV_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/gbkp_cell_store.sv
// Per-cell occupancy, winner-valid and winner payload memories with a clearing sweep.
// Depends on gbkp_pkg for the control and read-data structs.
module gbkp_cell_store #(
   parameter int  MAX_CELLS = gbkp_pkg::MAX_CELLS_DEF,
   localparam int CELL_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gbkp_pkg::store_ctl_type            ctl,
   input  logic [CELL_W-1:0]                  addr,
   input  logic signed [gbkp_pkg::RESP_W-1:0] wr_score,
   input  logic signed [gbkp_pkg::POS_W-1:0]  wr_x,
   input  logic signed [gbkp_pkg::POS_W-1:0]  wr_y,
   output gbkp_pkg::store_rd_type             rd
);
   import gbkp_pkg::*;

   localparam logic [CELL_W-1:0] LAST = CELL_W'(MAX_CELLS - 1);

   logic             occ_mem [MAX_CELLS];
   logic             val_mem [MAX_CELLS];
   logic [PAY_W-1:0] pay_mem [MAX_CELLS];

   logic              busy_ff;
   logic [CELL_W-1:0] cnt_ff;
   logic              clr_occ_ff;
   logic              clr_val_ff;
   logic              occ_rd_ff;
   logic              val_rd_ff;
   logic [PAY_W-1:0]  pay_rd_ff;

   logic              occ_we;
   logic              occ_wd;
   logic              val_we;
   logic              val_wd;
   logic [CELL_W-1:0] wr_addr;

   always_comb begin
      wr_addr = busy_ff ? cnt_ff : addr;
      occ_we  = busy_ff ? clr_occ_ff : ctl.occ_we;
      occ_wd  = busy_ff ? 1'b0 : ctl.occ_wd;
      val_we  = busy_ff ? clr_val_ff : ctl.val_we;
      val_wd  = busy_ff ? 1'b0 : ctl.val_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         cnt_ff     <= '0;
         clr_occ_ff <= 1'b1;
         clr_val_ff <= 1'b1;
      end else if (ctl.sweep_start) begin
         busy_ff    <= 1'b1;
         cnt_ff     <= '0;
         clr_occ_ff <= ctl.sweep_occ;
         clr_val_ff <= ctl.sweep_val;
      end else if (busy_ff) begin
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[wr_addr] <= occ_wd;
      end
      if (ctl.rd_en) begin
         occ_rd_ff <= occ_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[wr_addr] <= val_wd;
      end
      if (ctl.rd_en) begin
         val_rd_ff <= val_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pay_we && !busy_ff) begin
         pay_mem[addr] <= {wr_score, wr_y, wr_x};
      end
      if (ctl.rd_en) begin
         pay_rd_ff <= pay_mem[addr];
      end
   end

   always_comb begin
      rd.busy  = busy_ff;
      rd.occ   = occ_rd_ff;
      rd.valid = val_rd_ff;
      rd.score = pay_rd_ff[PAY_W-1:2*POS_W];
      rd.y     = pay_rd_ff[2*POS_W-1:POS_W];
      rd.x     = pay_rd_ff[POS_W-1:0];
   end

endmodule
